// File: rtl/mst_pkg.sv
`default_nettype none
package mst_pkg;
   localparam int MaxVertices = 64;
   localparam int VtxBits = 6;
   localparam int CntBits = 7;
   localparam int WeightBits = 16;
   localparam int AddrBits = 2 * VtxBits;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b00000000001,
      S_LOAD   = 11'b00000000010,
      S_FWD    = 11'b00000000100,
      S_SWAP   = 11'b00000001000,
      S_INIT   = 11'b00000010000,
      S_SCAN   = 11'b00000100000,
      S_PICK   = 11'b00001000000,
      S_RELAX  = 11'b00010000000,
      S_RDRAIN = 11'b00100000000,
      S_EMIT   = 11'b01000000000,
      S_WIPE   = 11'b10000000000
   } state_type;

   typedef struct packed {
      logic clear_mem;      // write absent at sweep address
      logic lookup;         // read stored entry a->b of the incoming edge
      logic store_fwd;      // edge write a->b
      logic store_rev;      // edge write b->a
      logic init_prim;
      logic scan_step;
      logic scan_start;
      logic pick;           // mark chosen vertex visited
      logic relax_start;
      logic relax_step;
      logic emit_start;
      logic emit_step;
      logic wipe_start;
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic store_keep;     // stored entry absent or new edge lighter than it
      logic scan_done;
      logic found;
      logic relax_done;
      logic emit_done;
      logic emit_ready;     // key and parent reads line up with the counter
      logic emit_has;       // current emit vertex is reached
      logic last_child;     // no reached vertex above the current one
      logic any_emitted;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/mst_datapath.sv
`default_nettype none
module mst_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mst_pkg::cmd_type              cmd,
   output mst_pkg::sts_type                   sts,
   input  wire logic [mst_pkg::CntBits-1:0]   n_eff,
   input  wire logic [mst_pkg::VtxBits-1:0]   edge_a,
   input  wire logic [mst_pkg::VtxBits-1:0]   edge_b,
   input  wire logic signed [mst_pkg::WeightBits-1:0] edge_w,
   output logic [mst_pkg::VtxBits-1:0]        out_parent,
   output logic [mst_pkg::VtxBits-1:0]        out_child,
   output logic signed [mst_pkg::WeightBits-1:0] out_weight
);
   localparam int VB = mst_pkg::VtxBits;
   localparam int CB = mst_pkg::CntBits;
   localparam int WB = mst_pkg::WeightBits;
   localparam int AB = mst_pkg::AddrBits;
   localparam int NV = mst_pkg::MaxVertices;

   // adjacency memory: {present, weight}
   logic [WB:0] adj_mem [0:NV*NV-1];
   logic [WB:0] adj_rd_ff;
   logic [AB-1:0] wr_addr;
   logic [WB:0] wr_data;
   logic wr_en;
   logic [AB-1:0] rd_addr;

   logic [NV-1:0] visited_ff, visited_in;
   logic [NV-1:0] reached_ff, reached_in;
   logic signed [WB-1:0] key_mem [0:NV-1];
   logic [VB-1:0] parent_mem [0:NV-1];
   logic signed [WB-1:0] key_rd_ff;
   logic [VB-1:0] parent_rd_ff;

   logic [CB-1:0] cnt_ff, cnt_in;       // scan / relax / emit counter
   logic [AB:0] sweep_ff, sweep_in;
   logic [VB-1:0] best_ff, best_in;
   logic signed [WB-1:0] best_key_ff, best_key_in;
   logic found_ff, found_in;
   logic [VB-1:0] cur_ff, cur_in;
   logic any_ff, any_in;
   // relax and scan pipelines: read issued for column cnt, data back in the next cycle
   logic rvalid_ff, rvalid_in;
   logic scan_vld_ff, scan_vld_in;
   logic [VB-1:0] rcol_ff, rcol_in;
   logic emit_ready_ff, emit_ready_in;

   logic [VB-1:0] cnt_v;
   assign cnt_v = cnt_ff[VB-1:0];

   // read port for adjacency
   always_comb begin
      rd_addr = cmd.lookup ? {edge_a, edge_b} : {cur_ff, cnt_v};
   end
   always_ff @(posedge clock) begin
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
      adj_rd_ff <= adj_mem[rd_addr];
   end

   // relax decision from registered row read
   logic [VB-1:0] rc;
   logic rel_upd;
   logic [WB:0] rd;
   assign rc = rcol_ff;
   assign rd = adj_rd_ff;
   always_comb begin
      rel_upd = rvalid_ff && rd[WB] && !visited_ff[rc] &&
                (!reached_ff[rc] || ($signed(rd[WB-1:0]) < key_rd_ff));
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = sweep_ff[AB-1:0];
      wr_data = '0;
      if (cmd.clear_mem) begin
         wr_en = 1'b1;
      end else if (cmd.store_fwd || cmd.store_rev) begin
         wr_en = 1'b1;
         wr_addr = cmd.store_fwd ? {edge_a, edge_b} : {edge_b, edge_a};
         wr_data = {1'b1, edge_w};
      end
   end

   logic scan_cand;
   always_comb begin
      scan_cand = scan_vld_ff && reached_ff[rc] && !visited_ff[rc];
   end

   always_comb begin
      visited_in = visited_ff;
      reached_in = reached_ff;
      cnt_in = cnt_ff;
      sweep_in = sweep_ff;
      best_in = best_ff;
      best_key_in = best_key_ff;
      found_in = found_ff;
      cur_in = cur_ff;
      any_in = any_ff;
      rvalid_in = 1'b0;
      scan_vld_in = 1'b0;
      rcol_in = cnt_v;
      emit_ready_in = !(cmd.emit_start || cmd.emit_step);
      if (cmd.clear_mem) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (cmd.wipe_start) begin
         sweep_in = '0;
         visited_in = '0;
         reached_in = '0;
      end
      if (cmd.init_prim) begin
         reached_in[0] = 1'b1;
         any_in = 1'b0;
      end
      if (cmd.scan_start) begin
         cnt_in = '0;
         found_in = 1'b0;
      end
      if (cmd.scan_step) begin
         scan_vld_in = 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end
      if (scan_cand && (!found_ff || key_rd_ff < best_key_ff)) begin
         best_in = rc;
         best_key_in = key_rd_ff;
         found_in = 1'b1;
      end
      if (cmd.pick) begin
         visited_in[best_ff] = 1'b1;
         cur_in = best_ff;
      end
      if (cmd.relax_start) begin
         cnt_in = '0;
      end
      if (cmd.relax_step) begin
         rvalid_in = 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end
      if (rel_upd) begin
         reached_in[rc] = 1'b1;
      end
      if (cmd.emit_start) begin
         cnt_in = CB'(1);
      end
      if (cmd.emit_step) begin
         if (reached_ff[cnt_v]) any_in = 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_prim) begin
         key_mem[0] <= '0;
         parent_mem[0] <= '0;
      end else if (rel_upd) begin
         key_mem[rc] <= $signed(rd[WB-1:0]);
         parent_mem[rc] <= cur_ff;
      end
      key_rd_ff <= key_mem[cnt_v];
      parent_rd_ff <= parent_mem[cnt_v];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         reached_ff <= '0;
         cnt_ff <= '0;
         sweep_ff <= '0;
         found_ff <= 1'b0;
         cur_ff <= '0;
         any_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         scan_vld_ff <= 1'b0;
         emit_ready_ff <= 1'b0;
      end else begin
         visited_ff <= visited_in;
         reached_ff <= reached_in;
         cnt_ff <= cnt_in;
         sweep_ff <= sweep_in;
         found_ff <= found_in;
         cur_ff <= cur_in;
         any_ff <= any_in;
         rvalid_ff <= rvalid_in;
         scan_vld_ff <= scan_vld_in;
         emit_ready_ff <= emit_ready_in;
      end
      best_ff <= best_in;
      best_key_ff <= best_key_in;
      rcol_ff <= rcol_in;
   end

   assign out_parent = parent_rd_ff;
   assign out_child = cnt_v;
   assign out_weight = key_rd_ff;

   // vertices above the current emit column that are still in use
   logic [NV-1:0] later_mask;
   always_comb begin
      for (int i = 0; i < NV; i++) begin
         later_mask[i] = (i > int'(cnt_v)) && (i < int'(n_eff));
      end
   end

   always_comb begin
      sts.sweep_done = sweep_ff[AB];
      sts.store_keep = !adj_rd_ff[WB] || (edge_w < $signed(adj_rd_ff[WB-1:0]));
      sts.scan_done = (cnt_ff >= n_eff);
      sts.found = found_ff;
      sts.relax_done = (cnt_ff >= n_eff);
      sts.emit_done = (cnt_ff >= n_eff);
      sts.emit_ready = emit_ready_ff;
      sts.emit_has = reached_ff[cnt_v];
      sts.last_child = ~|(reached_ff & later_mask);
      sts.any_emitted = any_ff;
   end
endmodule
`default_nettype wire

// File: rtl/mst_ctrl.sv
`default_nettype none
module mst_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_carries_edge,
   input  wire logic                   req_last_edge,
   input  wire logic                   edge_ok,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_edge_valid,
   output logic                        rsp_last_result,
   output mst_pkg::cmd_type            cmd,
   input  wire mst_pkg::sts_type       sts
);
   mst_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;

   logic acc;
   assign acc = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      rsp_edge_valid = 1'b0;
      rsp_last_result = 1'b0;
      case (state_ff)
         mst_pkg::S_CLEAR, mst_pkg::S_WIPE: begin
            cmd.clear_mem = 1'b1;
            if (sts.sweep_done) begin
               cmd.clear_mem = 1'b0;
               state_in = mst_pkg::S_LOAD;
            end
         end
         mst_pkg::S_LOAD: begin
            req_stall = 1'b0;
            if (acc) begin
               last_in = req_last_edge;
               if (req_carries_edge && edge_ok) begin
                  cmd.lookup = 1'b1;
                  state_in = mst_pkg::S_FWD;
               end else if (req_last_edge) begin
                  state_in = mst_pkg::S_INIT;
               end
            end
         end
         mst_pkg::S_FWD: begin
            // a heavier or equal duplicate leaves the stored edge alone
            if (sts.store_keep) begin
               cmd.store_fwd = 1'b1;
               state_in = mst_pkg::S_SWAP;
            end else begin
               state_in = last_ff ? mst_pkg::S_INIT : mst_pkg::S_LOAD;
            end
         end
         mst_pkg::S_SWAP: begin
            cmd.store_rev = 1'b1;
            state_in = last_ff ? mst_pkg::S_INIT : mst_pkg::S_LOAD;
         end
         mst_pkg::S_INIT: begin
            cmd.init_prim = 1'b1;
            cmd.scan_start = 1'b1;
            state_in = mst_pkg::S_SCAN;
         end
         mst_pkg::S_SCAN: begin
            if (sts.scan_done) begin
               state_in = mst_pkg::S_PICK;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         mst_pkg::S_PICK: begin
            if (sts.found) begin
               cmd.pick = 1'b1;
               cmd.relax_start = 1'b1;
               state_in = mst_pkg::S_RELAX;
            end else begin
               cmd.emit_start = 1'b1;
               state_in = mst_pkg::S_EMIT;
            end
         end
         mst_pkg::S_RELAX: begin
            if (sts.relax_done) begin
               state_in = mst_pkg::S_RDRAIN;
            end else begin
               cmd.relax_step = 1'b1;
            end
         end
         mst_pkg::S_RDRAIN: begin
            cmd.scan_start = 1'b1;
            state_in = mst_pkg::S_SCAN;
         end
         mst_pkg::S_EMIT: begin
            if (sts.emit_done) begin
               if (!sts.any_emitted) begin
                  rsp_valid = 1'b1;
                  rsp_last_result = 1'b1;
                  if (!rsp_stall) begin
                     cmd.wipe_start = 1'b1;
                     state_in = mst_pkg::S_WIPE;
                  end
               end else begin
                  cmd.wipe_start = 1'b1;
                  state_in = mst_pkg::S_WIPE;
               end
            end else if (sts.emit_ready) begin
               if (sts.emit_has) begin
                  rsp_valid = 1'b1;
                  rsp_edge_valid = 1'b1;
                  // final word when no later reached vertex
                  rsp_last_result = sts.last_child;
                  if (!rsp_stall) cmd.emit_step = 1'b1;
               end else begin
                  cmd.emit_step = 1'b1;
               end
            end
         end
         default: begin
            state_in = mst_pkg::S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mst_pkg::S_CLEAR;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/minimum_spanning_tree.sv
`default_nettype none
// Prim minimum spanning tree engine. A word without a storable edge is taken in S_LOAD;
// a word whose edge is stored then passes S_FWD and S_SWAP (a lookup of the stored entry,
// then one write per direction), or S_FWD alone when the stored weight is lower or equal.
// After reset and after each graph the 4096-entry adjacency memory is swept clear with
// req_stall high. The word with last_edge starts Prim from vertex 0: each round scans n
// keys then reads n row entries, for n = vertex_count. Tree edges then come out in
// rising child order, one vertex checked at a time, held by any rsp_stall.
module minimum_spanning_tree (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_write_enable,
   input  wire logic [6:0]   csr_write_data,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [5:0]   req_from_vertex,
   input  wire logic [5:0]   req_to_vertex,
   input  wire logic signed [15:0] req_edge_weight_in,
   input  wire logic         req_carries_edge,
   input  wire logic         req_last_edge,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [5:0]        rsp_parent_vertex,
   output logic [5:0]        rsp_child_vertex,
   output logic signed [15:0] rsp_tree_edge_weight,
   output logic              rsp_edge_valid,
   output logic              rsp_last_result
);
   logic [mst_pkg::CntBits-1:0] count_ff, n_eff;
   logic [5:0] a_ff, b_ff;
   logic signed [15:0] w_ff;
   mst_pkg::cmd_type cmd;
   mst_pkg::sts_type sts;
   logic edge_ok;
   logic [5:0] dp_parent;
   logic [5:0] dp_child;
   logic signed [15:0] dp_weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= mst_pkg::CntBits'(mst_pkg::MaxVertices);
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (count_ff == '0) n_eff = mst_pkg::CntBits'(1);
      else if (count_ff > mst_pkg::CntBits'(mst_pkg::MaxVertices))
         n_eff = mst_pkg::CntBits'(mst_pkg::MaxVertices);
      else n_eff = count_ff;
   end

   assign edge_ok = ({1'b0, req_from_vertex} < n_eff) && ({1'b0, req_to_vertex} < n_eff);

   // hold the edge for the compare and both writes
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         a_ff <= req_from_vertex;
         b_ff <= req_to_vertex;
         w_ff <= req_edge_weight_in;
      end
   end

   mst_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_carries_edge(req_carries_edge), .req_last_edge(req_last_edge),
      .edge_ok(edge_ok),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_edge_valid(rsp_edge_valid), .rsp_last_result(rsp_last_result),
      .cmd(cmd), .sts(sts)
   );

   logic [mst_pkg::VtxBits-1:0] ea;
   logic [mst_pkg::VtxBits-1:0] eb;
   assign ea = cmd.lookup ? req_from_vertex : a_ff;
   assign eb = cmd.lookup ? req_to_vertex : b_ff;

   mst_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .n_eff(n_eff),
      .edge_a(ea), .edge_b(eb), .edge_w(w_ff),
      .out_parent(dp_parent), .out_child(dp_child),
      .out_weight(dp_weight)
   );

   // the empty result carries zero fields
   assign rsp_parent_vertex = rsp_edge_valid ? dp_parent : '0;
   assign rsp_child_vertex = rsp_edge_valid ? dp_child : '0;
   assign rsp_tree_edge_weight = rsp_edge_valid ? dp_weight : '0;
endmodule
`default_nettype wire

// File: dv/tb_minimum_spanning_tree.sv
`default_nettype none
module tb_minimum_spanning_tree;
   localparam int WatchdogLimit = 50000;
   localparam int SettleCycles = 4300;
   localparam int HoldCycles = 700;

   typedef struct {
      logic [mst_pkg::VtxBits-1:0] parent;
      logic [mst_pkg::VtxBits-1:0] child;
      logic signed [mst_pkg::WeightBits-1:0] weight;
      logic edge_ok;
      logic is_last;
   } tree_edge_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [mst_pkg::CntBits-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [mst_pkg::VtxBits-1:0] req_from_vertex = '0;
   logic [mst_pkg::VtxBits-1:0] req_to_vertex = '0;
   logic signed [mst_pkg::WeightBits-1:0] req_edge_weight_in = '0;
   logic req_carries_edge = 1'b0;
   logic req_last_edge = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [mst_pkg::VtxBits-1:0] rsp_parent_vertex;
   logic [mst_pkg::VtxBits-1:0] rsp_child_vertex;
   logic signed [mst_pkg::WeightBits-1:0] rsp_tree_edge_weight;
   logic rsp_edge_valid;
   logic rsp_last_result;

   // graph as the block should hold it
   bit edge_there[mst_pkg::MaxVertices][mst_pkg::MaxVertices];
   logic signed [mst_pkg::WeightBits-1:0] edge_cost[mst_pkg::MaxVertices][mst_pkg::MaxVertices];
   int vertex_limit = mst_pkg::MaxVertices;
   tree_edge_type expected_tree_edges[$];

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int words_sent = 0;
   bit hold_armed = 1'b0;
   int hold_count = 0;

   minimum_spanning_tree u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex),
      .req_edge_weight_in(req_edge_weight_in),
      .req_carries_edge(req_carries_edge),
      .req_last_edge(req_last_edge),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_parent_vertex(rsp_parent_vertex),
      .rsp_child_vertex(rsp_child_vertex),
      .rsp_tree_edge_weight(rsp_tree_edge_weight),
      .rsp_edge_valid(rsp_edge_valid),
      .rsp_last_result(rsp_last_result)
   );

   always #5 clock = ~clock;

   function automatic void clear_graph();
      foreach (edge_there[a, b]) begin
         edge_there[a][b] = 1'b0;
         edge_cost[a][b] = '0;
      end
   endfunction

   function automatic void keep_lighter(int a, int b,
                                        logic signed [mst_pkg::WeightBits-1:0] w);
      if (!edge_there[a][b] || w < edge_cost[a][b]) begin
         edge_there[a][b] = 1'b1;
         edge_cost[a][b] = w;
      end
   endfunction

   function automatic void queue_edge(tree_edge_type e);
      expected_tree_edges = {expected_tree_edges, e};
   endfunction

   function automatic void solve_prim_tree();
      bit visited[mst_pkg::MaxVertices];
      bit reached[mst_pkg::MaxVertices];
      logic signed [mst_pkg::WeightBits-1:0] key[mst_pkg::MaxVertices];
      int parent_of[mst_pkg::MaxVertices];
      int best;
      int emitted;
      bit found;
      tree_edge_type e;
      foreach (visited[i]) begin
         visited[i] = 1'b0;
         reached[i] = 1'b0;
         key[i] = '0;
         parent_of[i] = 0;
      end
      reached[0] = 1'b1;
      for (int round = 0; round < vertex_limit; round++) begin
         found = 1'b0;
         best = 0;
         for (int i = 0; i < vertex_limit; i++) begin
            if (reached[i] && !visited[i] && (!found || key[i] < key[best])) begin
               best = i;
               found = 1'b1;
            end
         end
         if (!found) break;
         visited[best] = 1'b1;
         for (int v = 0; v < vertex_limit; v++) begin
            if (!edge_there[best][v] || visited[v]) continue;
            if (!reached[v] || edge_cost[best][v] < key[v]) begin
               reached[v] = 1'b1;
               key[v] = edge_cost[best][v];
               parent_of[v] = best;
            end
         end
      end
      emitted = 0;
      for (int v = 1; v < vertex_limit; v++) begin
         if (!reached[v]) continue;
         e.parent = mst_pkg::VtxBits'(parent_of[v]);
         e.child = mst_pkg::VtxBits'(v);
         e.weight = key[v];
         e.edge_ok = 1'b1;
         e.is_last = 1'b0;
         queue_edge(e);
         emitted++;
      end
      if (emitted == 0) begin
         e = '{parent: '0, child: '0, weight: '0, edge_ok: 1'b0, is_last: 1'b1};
         queue_edge(e);
      end else begin
         expected_tree_edges[expected_tree_edges.size()-1].is_last = 1'b1;
      end
      clear_graph();
   endfunction

   function automatic void take_word(int a, int b,
                                     logic signed [mst_pkg::WeightBits-1:0] w,
                                     bit carries, bit last);
      if (carries && a < vertex_limit && b < vertex_limit) begin
         keep_lighter(a, b, w);
         keep_lighter(b, a, w);
      end
      if (last) solve_prim_tree();
   endfunction

   task automatic send_word(int a, int b, int w, bit carries, bit last);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_from_vertex <= mst_pkg::VtxBits'(a);
      req_to_vertex <= mst_pkg::VtxBits'(b);
      req_edge_weight_in <= mst_pkg::WeightBits'(w);
      req_carries_edge <= carries;
      req_last_edge <= last;
      do @(posedge clock); while (req_stall);
      take_word(a, b, mst_pkg::WeightBits'(w), carries, last);
      words_sent++;
   endtask

   // block sweeps its memory after each graph, so wait that out too
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tree_edges.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_vertex_count(int value);
      drain_and_settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= mst_pkg::CntBits'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (value == 0) vertex_limit = 1;
      else if (value > mst_pkg::MaxVertices) vertex_limit = mst_pkg::MaxVertices;
      else vertex_limit = value;
   endtask

   task automatic send_random_graph(int n, int edges);
      int a, b, w;
      for (int k = 0; k < edges; k++) begin
         a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n-1);
         b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n-1);
         // narrow weights make ties
         w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) - 4 : $urandom_range(0, 65535);
         send_word(a, b, w, $urandom_range(0, 19) != 0, k == edges - 1);
      end
   endtask

   task automatic test_corner_graphs();
      // count left at its reset value of 64
      send_word(0, 63, -32768, 1, 0);
      send_word(63, 62, 32767, 1, 0);
      send_word(0, 62, 5, 1, 0);
      send_word(62, 0, 9, 1, 0);
      send_word(5, 5, -100, 1, 0);
      send_word(42, 21, 77, 0, 0);
      send_word(31, 32, -1, 1, 0);
      send_word(0, 0, 0, 0, 1);
      // graph of nothing gives the empty result
      send_word(0, 0, 0, 0, 1);
      write_vertex_count(3);
      send_word(1, 2, 4, 1, 0);
      send_word(0, 5, -9, 1, 0);
      send_word(0, 1, 4, 1, 0);
      send_word(0, 2, 4, 1, 1);
      write_vertex_count(0);
      send_word(0, 0, 1, 1, 0);
      send_word(1, 0, 1, 1, 1);
      write_vertex_count(127);
      send_word(63, 0, 12345, 1, 0);
      send_word(1, 63, -2, 1, 1);
      write_vertex_count(1);
      send_word(0, 0, 3, 1, 1);
   endtask

   task automatic test_random_graphs(int idle_pct, int stall_pct, int words);
      int n;
      int stop_at;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at = words_sent + words;
      while (words_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: n = 64;
            1: n = 2;
            default: n = $urandom_range(2, 12);
         endcase
         write_vertex_count(n);
         send_random_graph(n, $urandom_range(1, (n > 12) ? 40 : 2 * n));
      end
   endtask

   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_vertex_count(48);
      hold_armed <= 1'b1;
      for (int v = 1; v < 48; v++) send_word(v - 1, v, $urandom_range(0, 65535), 1, v == 47);
      send_random_graph(48, 10);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_corner_graphs();
      test_random_graphs(0, 0, 60);
      test_random_graphs(52, 0, 55);
      test_random_graphs(0, 52, 55);
      test_random_graphs(23, 23, 55);
      test_backpressure();
      drain_and_settle();
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // result side: random stall, one long hold once words come out, compare each word
   always @(posedge clock) begin
      tree_edge_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tree_edges.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected word parent %0d child %0d",
                                              rsp_parent_vertex, rsp_child_vertex);
            end else begin
               e = expected_tree_edges.pop_front();
               if (rsp_parent_vertex !== e.parent || rsp_child_vertex !== e.child ||
                   rsp_tree_edge_weight !== e.weight || rsp_edge_valid !== e.edge_ok ||
                   rsp_last_result !== e.is_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp %0d-%0d w %0d v%0d l%0d got %0d-%0d w %0d v%0d l%0d",
                              e.parent, e.child, e.weight, e.edge_ok, e.is_last,
                              rsp_parent_vertex, rsp_child_vertex, rsp_tree_edge_weight,
                              rsp_edge_valid, rsp_last_result);
               end
            end
         end
         if (hold_armed && hold_count < HoldCycles && (hold_count > 0 || rsp_valid)) begin
            hold_count <= hold_count + 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= $urandom_range(0, 99) < receiver_stall_pct;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end
endmodule
`default_nettype wire
